// File: hw/rtl/mtt_pkg.sv
// Shared types and constants for the matrix times transpose block.
package mtt_pkg;

  localparam int DEF_MAX_ROWS = 8;
  localparam int DEF_MAX_LEN  = 16;

  localparam int ROW_W      = 3;
  localparam int COL_W      = 4;
  localparam int VAL_W      = 16;
  localparam int PROD_W     = 32;
  localparam int OUT_W      = 36;
  localparam int K_MAX_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_START = 1'b1;
  localparam logic SEL_A     = 1'b0;
  localparam logic SEL_B     = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd2;

  typedef struct packed {
    logic               load;
    logic               rd_valid;
    logic [ROW_W-1:0]   row_a;
    logic [ROW_W-1:0]   row_b;
    logic [K_MAX_W-1:0] k;
    logic               first;
    logic               last_k;
    logic               last_entry;
  } mtt_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } mtt_sts_t;

endpackage

// File: hw/rtl/mtt_ram.sv
// Generic simple dual-port RAM with registered read.
module mtt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/mtt_ctrl.sv
// Controller: configuration registers and the row/row/element sequencer.
module mtt_ctrl import mtt_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_LEN  = DEF_MAX_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  req_type,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  mtt_sts_t              sts,
  output logic                  busy,
  output mtt_cmd_t              cmd
);

  localparam int KW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DRAIN
  } state_t;

  state_t           state;
  logic [3:0]       rows_a;
  logic [3:0]       rows_b;
  logic [4:0]       row_length;
  logic [ROW_W-1:0] i;
  logic [ROW_W-1:0] j;
  logic [KW-1:0]    k;

  logic [ROW_W-1:0] na_m1;
  logic [ROW_W-1:0] nb_m1;
  logic [KW-1:0]    len_m1;
  logic             accept;

  always_comb begin
    if (rows_a == 4'd0) begin
      na_m1 = '0;
    end else if (rows_a > 4'(MAX_ROWS)) begin
      na_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      na_m1 = ROW_W'(rows_a - 4'd1);
    end
    if (rows_b == 4'd0) begin
      nb_m1 = '0;
    end else if (rows_b > 4'(MAX_ROWS)) begin
      nb_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      nb_m1 = ROW_W'(rows_b - 4'd1);
    end
    if (row_length == 5'd0) begin
      len_m1 = '0;
    end else if ({2'b00, row_length} > 7'(MAX_LEN)) begin
      len_m1 = KW'(MAX_LEN - 1);
    end else begin
      len_m1 = KW'(row_length - 5'd1);
    end
  end

  assign busy   = (state != IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd            = '0;
    cmd.load       = accept && (req_type == REQ_LOAD);
    cmd.rd_valid   = (state == RUN);
    cmd.row_a      = i;
    cmd.row_b      = j;
    cmd.k          = K_MAX_W'(k);
    cmd.first      = (k == '0);
    cmd.last_k     = (k == len_m1);
    cmd.last_entry = (i == na_m1) && (j == nb_m1) && (k == len_m1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      rows_a     <= 4'd8;
      rows_b     <= 4'd8;
      row_length <= 5'd16;
      i          <= '0;
      j          <= '0;
      k          <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ROWS_A:     rows_a     <= cfg_data[3:0];
          CFG_ROWS_B:     rows_b     <= cfg_data[3:0];
          CFG_ROW_LENGTH: row_length <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        IDLE: begin
          i <= '0;
          j <= '0;
          k <= '0;
          if (accept && (req_type == REQ_START)) begin
            state <= RUN;
          end
        end
        RUN: begin
          if (k == len_m1) begin
            k <= '0;
            if (j == nb_m1) begin
              j <= '0;
              if (i == na_m1) begin
                state <= DRAIN;
              end else begin
                i <= i + 1'b1;
              end
            end else begin
              j <= j + 1'b1;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        DRAIN: begin
          if (!sts.pipe_busy) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/mtt_dpath.sv
// Datapath: element stores, multiplier and accumulator with result register.
module mtt_dpath import mtt_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_LEN  = DEF_MAX_LEN
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mtt_cmd_t                cmd,
  input  logic                    matrix_sel,
  input  logic [ROW_W-1:0]        elem_row,
  input  logic [COL_W-1:0]        elem_col,
  input  logic signed [VAL_W-1:0] elem_value,
  output mtt_sts_t                sts,
  output logic                    out_valid,
  output logic [ROW_W-1:0]        out_row,
  output logic [ROW_W-1:0]        out_col,
  output logic signed [OUT_W-1:0] out_value,
  output logic                    out_last
);

  localparam int DEPTH = MAX_ROWS * MAX_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic          wr_ok;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic [VAL_W-1:0] rd_a;
  logic [VAL_W-1:0] rd_b;

  // stage 1: store read
  logic             v1;
  logic             first1, last_k1, last_e1;
  logic [ROW_W-1:0] row1, col1;
  // stage 2: product
  logic                     v2;
  logic                     first2, last_k2, last_e2;
  logic [ROW_W-1:0]         row2, col2;
  logic signed [PROD_W-1:0] prod;
  // stage 3: accumulate
  logic signed [OUT_W-1:0] acc;
  logic signed [OUT_W-1:0] acc_next;

  assign wr_ok = cmd.load
              && ({1'b0, elem_row} < 4'(MAX_ROWS))
              && ({3'b000, elem_col} < 7'(MAX_LEN));
  assign wr_addr   = AW'(elem_row) * AW'(MAX_LEN) + AW'(elem_col);
  assign rd_addr_a = AW'(cmd.row_a) * AW'(MAX_LEN) + AW'(cmd.k[KW-1:0]);
  assign rd_addr_b = AW'(cmd.row_b) * AW'(MAX_LEN) + AW'(cmd.k[KW-1:0]);

  mtt_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store_a (
    .clk     (clk),
    .wr_en   (wr_ok && (matrix_sel == SEL_A)),
    .wr_addr (wr_addr),
    .wr_data (elem_value),
    .rd_addr (rd_addr_a),
    .rd_data (rd_a)
  );

  mtt_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store_b (
    .clk     (clk),
    .wr_en   (wr_ok && (matrix_sel == SEL_B)),
    .wr_addr (wr_addr),
    .wr_data (elem_value),
    .rd_addr (rd_addr_b),
    .rd_data (rd_b)
  );

  assign acc_next = first2 ? {{(OUT_W-PROD_W){prod[PROD_W-1]}}, prod}
                           : acc + {{(OUT_W-PROD_W){prod[PROD_W-1]}}, prod};

  assign sts.pipe_busy = v1 || v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= cmd.rd_valid;
      v2        <= v1;
      out_valid <= v2 && last_k2;
    end
    first1  <= cmd.first;
    last_k1 <= cmd.last_k;
    last_e1 <= cmd.last_entry;
    row1    <= cmd.row_a;
    col1    <= cmd.row_b;

    first2  <= first1;
    last_k2 <= last_k1;
    last_e2 <= last_e1;
    row2    <= row1;
    col2    <= col1;
    prod    <= $signed(rd_a) * $signed(rd_b);

    if (v2) begin
      acc <= acc_next;
    end
    if (v2 && last_k2) begin
      out_row   <= row2;
      out_col   <= col2;
      out_value <= acc_next;
      out_last  <= last_e2;
    end
  end

endmodule

// File: hw/rtl/matrix_times_transpose.sv
// Matrix times transpose: C = A * B^T over Q8.8 element stores.
// Load word: written in the cycle it is taken, one per cycle while not busy, busy stays low.
// Start word: one multiply-accumulate per cycle; each entry sums row_length
// products through the store read, product and accumulate stages, and busy
// holds until the final entry has been presented.
// Reset clears control and sets rows_a = 8, rows_b = 8, row_length = 16;
// the element stores are not cleared. Results cannot be stalled.
module matrix_times_transpose import mtt_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_LEN  = DEF_MAX_LEN
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    req_type,
  input  logic                    matrix_sel,
  input  logic [ROW_W-1:0]        elem_row,
  input  logic [COL_W-1:0]        elem_col,
  input  logic signed [VAL_W-1:0] elem_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    out_valid,
  output logic [ROW_W-1:0]        out_row,
  output logic [ROW_W-1:0]        out_col,
  output logic signed [OUT_W-1:0] out_value,
  output logic                    out_last
);

  mtt_cmd_t cmd;
  mtt_sts_t sts;

  assign cfg_ready = 1'b1;

  mtt_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_LEN(MAX_LEN)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req_type),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd)
  );

  mtt_dpath #(.MAX_ROWS(MAX_ROWS), .MAX_LEN(MAX_LEN)) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .matrix_sel (matrix_sel),
    .elem_row   (elem_row),
    .elem_col   (elem_col),
    .elem_value (elem_value),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .out_last   (out_last)
  );

`ifndef SYNTHESIS
  a_out_while_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy)
    else $error("result word outside a busy period");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |=> !out_valid)
    else $error("result word after the final entry");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req_type == REQ_START) |=> busy)
    else $error("start word did not raise busy");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req_type == REQ_LOAD) |=> !busy)
    else $error("load word raised busy");
`endif

endmodule

// File: verif/mtt_product_checker.sv
`timescale 1ns / 1ps
// Product checker: tracks stores and shape registers, predicts C = A * B^T entries, compares.
module mtt_product_checker import mtt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    req_type,
  input  logic                    matrix_sel,
  input  logic [ROW_W-1:0]        elem_row,
  input  logic [COL_W-1:0]        elem_col,
  input  logic signed [VAL_W-1:0] elem_value,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    out_valid,
  input  logic [ROW_W-1:0]        out_row,
  input  logic [ROW_W-1:0]        out_col,
  input  logic signed [OUT_W-1:0] out_value,
  input  logic                    out_last,
  input  logic                    end_check,
  output int                      errors,
  output int                      outstanding,
  output int                      entries_checked
);

  typedef struct {
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
    logic signed [OUT_W-1:0] value;
    logic                    last;
  } entry_t;

  entry_t                  product_q[$];
  logic signed [VAL_W-1:0] elems_a [DEF_MAX_ROWS][DEF_MAX_LEN];
  logic signed [VAL_W-1:0] elems_b [DEF_MAX_ROWS][DEF_MAX_LEN];
  logic [3:0]              rows_a_reg;
  logic [3:0]              rows_b_reg;
  logic [4:0]              length_reg;
  bit                      leftovers_reported;

  initial begin
    errors = 0;
    outstanding = 0;
    entries_checked = 0;
    leftovers_reported = 0;
    rows_a_reg = 4'd8;
    rows_b_reg = 4'd8;
    length_reg = 5'd16;
    foreach (elems_a[r, c]) begin
      elems_a[r][c] = '0;
      elems_b[r][c] = '0;
    end
  end

  function automatic int clamp_count(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] dot_product(int ra, int rb, int len);
    logic signed [47:0] acc;
    acc = '0;
    for (int k = 0; k < len; k++) acc += elems_a[ra][k] * elems_b[rb][k];
    return acc[OUT_W-1:0];
  endfunction

  task automatic predict_product();
    int     na;
    int     nb;
    int     len;
    entry_t e;
    na = clamp_count(rows_a_reg, DEF_MAX_ROWS);
    nb = clamp_count(rows_b_reg, DEF_MAX_ROWS);
    len = clamp_count(length_reg, DEF_MAX_LEN);
    for (int i = 0; i < na; i++) begin
      for (int j = 0; j < nb; j++) begin
        e.row = ROW_W'(i);
        e.col = ROW_W'(j);
        e.value = dot_product(i, j, len);
        e.last = (i == na - 1) && (j == nb - 1);
        product_q.push_back(e);
      end
    end
  endtask

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    entry_t want;
    if (rst) begin
      rows_a_reg = 4'd8;
      rows_b_reg = 4'd8;
      length_reg = 5'd16;
      product_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROWS_A:     rows_a_reg = cfg_data[3:0];
          CFG_ROWS_B:     rows_b_reg = cfg_data[3:0];
          CFG_ROW_LENGTH: length_reg = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (req_type == REQ_LOAD) begin
          if (matrix_sel == SEL_A) elems_a[elem_row][elem_col] = elem_value;
          else elems_b[elem_row][elem_col] = elem_value;
        end else begin
          predict_product();
        end
      end
      if (out_valid) begin
        if (product_q.size() == 0) begin
          report_mismatch($sformatf("unexpected entry (%0d,%0d) value %0d last %0b",
                                    out_row, out_col, out_value, out_last));
        end else begin
          want = product_q.pop_front();
          entries_checked++;
          if (out_row !== want.row || out_col !== want.col || out_value !== want.value ||
              out_last !== want.last)
            report_mismatch($sformatf("got (%0d,%0d) %0d last %0b, want (%0d,%0d) %0d last %0b",
                                      out_row, out_col, out_value, out_last,
                                      want.row, want.col, want.value, want.last));
        end
      end
      if (end_check && !leftovers_reported) begin
        leftovers_reported = 1;
        if (product_q.size() != 0)
          report_mismatch($sformatf("%0d product entries never arrived", product_q.size()));
      end
    end
    outstanding <= product_q.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench top: drives element loads, product starts and shape register writes, gives verdict.
module tb;
  import mtt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int TARGET_WORDS = 210;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    req_type = REQ_LOAD;
  logic                    matrix_sel = SEL_A;
  logic [ROW_W-1:0]        elem_row = '0;
  logic [COL_W-1:0]        elem_col = '0;
  logic signed [VAL_W-1:0] elem_value = '0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    out_valid;
  logic [ROW_W-1:0]        out_row;
  logic [ROW_W-1:0]        out_col;
  logic signed [OUT_W-1:0] out_value;
  logic                    out_last;
  logic                    end_check = 1'b0;
  int                      errors;
  int                      outstanding;
  int                      entries_checked;

  bit written_a [DEF_MAX_ROWS][DEF_MAX_LEN];
  bit written_b [DEF_MAX_ROWS][DEF_MAX_LEN];
  int use_rows_a = DEF_MAX_ROWS;
  int use_rows_b = DEF_MAX_ROWS;
  int use_len = DEF_MAX_LEN;
  int words_sent = 0;
  int starts_sent = 0;
  int cfg_writes = 0;
  int burst_left = 0;

  matrix_times_transpose dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .matrix_sel(matrix_sel), .elem_row(elem_row),
    .elem_col(elem_col), .elem_value(elem_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_row(out_row), .out_col(out_col),
    .out_value(out_value), .out_last(out_last)
  );

  mtt_product_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .matrix_sel(matrix_sel), .elem_row(elem_row),
    .elem_col(elem_col), .elem_value(elem_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_row(out_row), .out_col(out_col),
    .out_value(out_value), .out_last(out_last),
    .end_check(end_check), .errors(errors), .outstanding(outstanding),
    .entries_checked(entries_checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("Run exceeded its time limit");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int clamp_count(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return VAL_W'($urandom_range(0, 511)) - 16'sd256;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // bursts of back-to-back words separated by short idle gaps
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_word(logic kind, logic sel, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic signed [VAL_W-1:0] value);
    start <= 1'b1;
    req_type <= kind;
    matrix_sel <= sel;
    elem_row <= row;
    elem_col <= col;
    elem_value <= value;
    do @(posedge clk); while (busy);
    words_sent++;
    if (kind == REQ_LOAD) begin
      if (sel == SEL_A) written_a[row][col] = 1;
      else written_b[row][col] = 1;
    end else begin
      starts_sent++;
    end
    pace_sender();
  endtask

  task automatic load_elem(logic sel, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic signed [VAL_W-1:0] value);
    send_word(REQ_LOAD, sel, row, col, value);
  endtask

  // every element the next product reads must have been written
  task automatic start_product();
    for (int r = 0; r < use_rows_a; r++)
      for (int c = 0; c < use_len; c++)
        if (!written_a[r][c]) load_elem(SEL_A, ROW_W'(r), COL_W'(c), pick_value());
    for (int r = 0; r < use_rows_b; r++)
      for (int c = 0; c < use_len; c++)
        if (!written_b[r][c]) load_elem(SEL_B, ROW_W'(r), COL_W'(c), pick_value());
    send_word(REQ_START, 1'($urandom), ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data, bit last_one);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    if (last_one || $urandom_range(0, 1) == 0) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic program_shape(int ra, int rb, int len);
    write_reg(CFG_ROWS_A, CFG_DATA_W'(ra), 0);
    write_reg(CFG_ROWS_B, CFG_DATA_W'(rb), 0);
    write_reg(CFG_ROW_LENGTH, CFG_DATA_W'(len), 1);
    use_rows_a = clamp_count(ra & 15, DEF_MAX_ROWS);
    use_rows_b = clamp_count(rb & 15, DEF_MAX_ROWS);
    use_len = clamp_count(len & 31, DEF_MAX_LEN);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_in_use();
    logic sel;
    sel = 1'($urandom);
    if (sel == SEL_A)
      load_elem(SEL_A, ROW_W'($urandom_range(0, use_rows_a - 1)),
                COL_W'($urandom_range(0, use_len - 1)), pick_value());
    else
      load_elem(SEL_B, ROW_W'($urandom_range(0, use_rows_b - 1)),
                COL_W'($urandom_range(0, use_len - 1)), pick_value());
  endtask

  task automatic random_phase(int mode);
    int                      ra;
    int                      rb;
    int                      len;
    logic signed [VAL_W-1:0] fill_b;
    case (mode)
      0: begin
        ra = $urandom_range(1, 3);
        rb = $urandom_range(1, 3);
        len = $urandom_range(1, 6);
      end
      1: begin
        ra = $urandom_range(0, 1) ? 8 : $urandom_range(0, 31);
        rb = $urandom_range(0, 1) ? 8 : $urandom_range(0, 31);
        len = $urandom_range(1, 2);
      end
      2: begin
        ra = $urandom_range(1, 2);
        rb = $urandom_range(1, 2);
        len = $urandom_range(0, 1) ? 0 : $urandom_range(16, 31);
      end
      default: begin
        ra = 1;
        rb = 1;
        len = $urandom_range(16, 31);
      end
    endcase
    program_shape(ra, rb, len);
    repeat ($urandom_range(0, 8))
      load_elem(1'($urandom), ROW_W'($urandom), COL_W'($urandom), pick_value());
    if (mode == 3) begin
      // full-length rows of extreme values give the largest sums
      fill_b = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      for (int c = 0; c < DEF_MAX_LEN; c++) begin
        load_elem(SEL_A, 3'd0, COL_W'(c), 16'sh8000);
        load_elem(SEL_B, 3'd0, COL_W'(c), fill_b);
      end
    end
    start_product();
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 4)) load_in_use();
      start_product();
    end
  endtask

  initial begin
    int phase;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    program_shape(2, 2, 2);
    load_elem(SEL_A, 3'd0, 4'd0, 16'sh8000);
    load_elem(SEL_A, 3'd0, 4'd1, 16'sh8000);
    load_elem(SEL_A, 3'd1, 4'd0, 16'sh7fff);
    load_elem(SEL_A, 3'd1, 4'd1, 16'sh0000);
    load_elem(SEL_B, 3'd0, 4'd0, 16'sh8000);
    load_elem(SEL_B, 3'd0, 4'd1, 16'sh8000);
    load_elem(SEL_B, 3'd1, 4'd0, 16'sh8000);
    load_elem(SEL_B, 3'd1, 4'd1, 16'sh0001);
    start_product();
    wait_idle();

    // rows_a below range, rows_b above range, write to the unused index
    write_reg(CFG_UNUSED, 5'h1f, 1);
    program_shape(0, 15, 1);
    for (int r = 2; r < DEF_MAX_ROWS; r++)
      load_elem(SEL_B, ROW_W'(r), 4'd0, r[0] ? 16'sh8000 : 16'sh7fff);
    load_elem(SEL_A, 3'd7, 4'd15, 16'sh7fff);
    load_elem(SEL_B, 3'd7, 4'd15, 16'sh8000);
    start_product();

    phase = 0;
    while (words_sent < TARGET_WORDS) begin
      wait_idle();
      if (phase == 0) random_phase(3);
      else if (phase == 1) random_phase(1);
      else random_phase($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3));
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Covered %0d words (%0d product starts) and %0d register writes",
             words_sent, starts_sent, cfg_writes);
    $display("Compared %0d product entries against prediction", entries_checked);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
